/* rtl/core/i2cms_pkg.sv */
package i2cms_pkg;

   // default sizes of the transmit buffer and of a read
   localparam int TX_DEPTH_DEF = 32;
   localparam int RX_DEPTH_DEF = 32;

   // depth of the queues between front, back and result port
   localparam int QUEUE_DEPTH = 2;

   // software command codes
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_EVENT = 2'd3;

   // two-wire status codes, low three bits masked
   localparam logic [7:0] ST_BUS_ERROR  = 8'h00;
   localparam logic [7:0] ST_START      = 8'h08;
   localparam logic [7:0] ST_REP_START  = 8'h10;
   localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
   localparam logic [7:0] ST_SLA_W_NACK = 8'h20;
   localparam logic [7:0] ST_DATA_ACK   = 8'h28;
   localparam logic [7:0] ST_DATA_NACK  = 8'h30;
   localparam logic [7:0] ST_ARB_LOST   = 8'h38;
   localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
   localparam logic [7:0] ST_SLA_R_NACK = 8'h48;
   localparam logic [7:0] ST_RX_ACK     = 8'h50;
   localparam logic [7:0] ST_RX_NACK    = 8'h58;
   localparam logic [7:0] STATUS_MASK   = 8'hF8;

   // recorded status values
   localparam logic [7:0] ERR_NONE        = 8'hFF;
   localparam logic [7:0] ERR_IN_PROGRESS = 8'hF8;
   localparam logic [7:0] ERR_BUS         = 8'h00;

   // reply codes of start commands
   localparam logic [1:0] REPLY_OK       = 2'd0;
   localparam logic [1:0] REPLY_TOO_LONG = 2'd1;
   localparam logic [1:0] REPLY_BUSY     = 2'd2;

   typedef enum logic [3:0] {
      OP_LOAD,
      OP_WRITE,
      OP_READ,
      OP_SEND_MORE,
      OP_MT_ACK,
      OP_MR_ADDR,
      OP_RX_ACK,
      OP_RX_LAST,
      OP_FAIL,
      OP_REP,
      OP_BUS_ERROR,
      OP_NOP
   } op_type;

   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_START = 3'd1,
      ACT_STOP  = 3'd2,
      ACT_SEND  = 3'd3,
      ACT_ACK   = 3'd4,
      ACT_NACK  = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      MODE_READY = 3'd0,
      MODE_INIT  = 3'd1,
      MODE_REP   = 3'd2,
      MODE_MT    = 3'd3,
      MODE_MR    = 3'd4
   } mode_type;

   // classified item handed from front to back
   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic [4:0] slot;
      logic       slot_ok;
      logic [7:0] length;
      logic       too_long;
      logic       rep;
      logic [7:0] addr_byte;
      logic [7:0] err_code;
   } cmd_type;

   typedef struct packed {
      action_type bus_action;
      logic [7:0] tx_byte;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic [4:0] rx_slot;
      logic [1:0] reply_code;
      logic       ready_res;
      mode_type   link_mode;
      logic [7:0] error_code;
   } rsp_type;

endpackage

/* rtl/core/i2c_master_transfer_sequencer.sv */
// channel    | ports                           | transfer when
// -----------+---------------------------------+----------------------------
// request    | push, full, req_*               | push high and full low
// response   | empty, pop, rsp_*               | pop high and empty low
//
// one item per clock sustained while neither side stalls; a response passes
// through the command queue and the response queue; the back end executes one
// item per cycle unless the response queue is full, with the transmit buffer
// read in the same cycle; both queues are two deep so either side may stall alone
// reset is synchronous and active high; it empties both queues and returns
// the link to ready with no recorded error; buffer contents are kept
module i2c_master_transfer_sequencer
   import i2cms_pkg::*;
#(
   parameter int TX_DEPTH = TX_DEPTH_DEF,
   parameter int RX_DEPTH = RX_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   // request side
   input  logic       push,
   output logic       full,
   input  logic [1:0] req_command,
   input  logic [7:0] req_data_byte,
   input  logic [4:0] req_buffer_slot,
   input  logic [7:0] req_length,
   input  logic       req_rep_start,
   input  logic [6:0] req_slave_address,
   input  logic [7:0] req_status_code,
   // response side
   output logic       empty,
   input  logic       pop,
   output logic [2:0] rsp_bus_action,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_byte,
   output logic [4:0] rsp_rx_slot,
   output logic [1:0] rsp_reply_code,
   output logic       rsp_ready_res,
   output logic [2:0] rsp_link_mode,
   output logic [7:0] rsp_error_code
);

   // classified command between front and back
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_take;

   // result from back into the response queue
   logic    rsp_push;
   rsp_type rsp_new;
   logic    rsp_full;
   rsp_type rsp_head;
   logic [$bits(rsp_type)-1:0] rsp_bits;

   // front: decode command and status class, queue it
   i2cms_front #(
      .TX_DEPTH (TX_DEPTH),
      .RX_DEPTH (RX_DEPTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_command       (req_command),
      .req_data_byte     (req_data_byte),
      .req_buffer_slot   (req_buffer_slot),
      .req_length        (req_length),
      .req_rep_start     (req_rep_start),
      .req_slave_address (req_slave_address),
      .req_status_code   (req_status_code),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_take          (cmd_take)
   );

   // back: holds the link state and transmit buffer, picks the bus action
   i2cms_back #(
      .TX_DEPTH (TX_DEPTH),
      .RX_DEPTH (RX_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_push  (rsp_push),
      .rsp       (rsp_new),
      .rsp_full  (rsp_full)
   );

   // response queue decouples the back end from a stalled consumer
   i2cms_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_new),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_bits),
      .empty   (empty)
   );

   assign rsp_head       = rsp_type'(rsp_bits);
   assign rsp_bus_action = rsp_head.bus_action;
   assign rsp_tx_byte    = rsp_head.tx_byte;
   assign rsp_rx_valid   = rsp_head.rx_valid;
   assign rsp_rx_byte    = rsp_head.rx_byte;
   assign rsp_rx_slot    = rsp_head.rx_slot;
   assign rsp_reply_code = rsp_head.reply_code;
   assign rsp_ready_res  = rsp_head.ready_res;
   assign rsp_link_mode  = rsp_head.link_mode;
   assign rsp_error_code = rsp_head.error_code;

endmodule

/* rtl/core/i2cms_fifo.sv */
module i2cms_fifo
   import i2cms_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* rtl/core/i2cms_front.sv */
module i2cms_front
   import i2cms_pkg::*;
#(
   parameter int TX_DEPTH = TX_DEPTH_DEF,
   parameter int RX_DEPTH = RX_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [1:0] req_command,
   input  logic [7:0] req_data_byte,
   input  logic [4:0] req_buffer_slot,
   input  logic [7:0] req_length,
   input  logic       req_rep_start,
   input  logic [6:0] req_slave_address,
   input  logic [7:0] req_status_code,
   output logic       cmd_valid,
   output cmd_type    cmd,
   input  logic       cmd_take
);

   cmd_type    cmd_new;
   logic [7:0] status_m;
   logic       cmd_empty;
   logic [$bits(cmd_type)-1:0] cmd_bits;

   assign status_m = req_status_code & STATUS_MASK;

   always_comb begin
      cmd_new           = '0;
      cmd_new.data      = req_data_byte;
      cmd_new.slot      = req_buffer_slot;
      cmd_new.slot_ok   = (9'(req_buffer_slot) < 9'(TX_DEPTH));
      cmd_new.length    = req_length;
      cmd_new.rep       = req_rep_start;
      cmd_new.addr_byte = {req_slave_address, 1'b1};
      cmd_new.err_code  = status_m;
      cmd_new.op        = OP_NOP;
      cmd_new.too_long  = 1'b0;
      case (req_command)
         CMD_LOAD: begin
            cmd_new.op = OP_LOAD;
         end
         CMD_WRITE: begin
            cmd_new.op       = OP_WRITE;
            cmd_new.too_long = ({1'b0, req_length} > 9'(TX_DEPTH));
         end
         CMD_READ: begin
            cmd_new.op       = OP_READ;
            cmd_new.too_long = ({1'b0, req_length} > 9'(RX_DEPTH));
         end
         default: begin
            case (status_m)
               ST_START, ST_DATA_ACK:                           cmd_new.op = OP_SEND_MORE;
               ST_SLA_W_ACK:                                    cmd_new.op = OP_MT_ACK;
               ST_SLA_R_ACK:                                    cmd_new.op = OP_MR_ADDR;
               ST_RX_ACK:                                       cmd_new.op = OP_RX_ACK;
               ST_RX_NACK:                                      cmd_new.op = OP_RX_LAST;
               ST_SLA_W_NACK, ST_DATA_NACK, ST_ARB_LOST, ST_SLA_R_NACK:
                                                                cmd_new.op = OP_FAIL;
               ST_REP_START:                                    cmd_new.op = OP_REP;
               ST_BUS_ERROR:                                    cmd_new.op = OP_BUS_ERROR;
               default:                                         cmd_new.op = OP_NOP;
            endcase
         end
      endcase
   end

   i2cms_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (cmd_new),
      .full    (full),
      .rd_en   (cmd_take),
      .rd_data (cmd_bits),
      .empty   (cmd_empty)
   );

   assign cmd       = cmd_type'(cmd_bits);
   assign cmd_valid = !cmd_empty;

endmodule

/* rtl/core/i2cms_back.sv */
module i2cms_back
   import i2cms_pkg::*;
#(
   parameter int TX_DEPTH = TX_DEPTH_DEF,
   parameter int RX_DEPTH = RX_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_take,
   output logic    rsp_push,
   output rsp_type rsp,
   input  logic    rsp_full
);

   localparam int TX_IDX_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);
   localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);

   logic [7:0]          tx_buf_ff [TX_DEPTH];
   logic [TX_CNT_W-1:0] tx_count_ff, tx_count_in;
   logic [TX_CNT_W-1:0] tx_pos_ff, tx_pos_in;
   logic [RX_CNT_W-1:0] rx_count_ff, rx_count_in;
   logic [RX_CNT_W-1:0] rx_pos_ff, rx_pos_in;
   mode_type            mode_ff, mode_in;
   logic [7:0]          last_err_ff, last_err_in;
   logic                hold_ff, hold_in;

   logic                wr_en;
   logic [TX_IDX_W-1:0] wr_idx;
   logic [7:0]          wr_data;
   logic [TX_IDX_W-1:0] rd_idx;
   logic [7:0]          buf_rd;
   logic                ready_now;
   logic                begin_en, next_en, take_en, ackn_en, finish_en;
   logic [TX_CNT_W-1:0] begin_len;
   logic [7:0]          finish_err;

   assign cmd_take  = cmd_valid && !rsp_full;
   assign rsp_push  = cmd_take;
   assign ready_now = (mode_ff == MODE_READY) || (mode_ff == MODE_REP);
   assign buf_rd    = tx_buf_ff[rd_idx];

   always_comb begin
      tx_count_in = tx_count_ff;
      tx_pos_in   = tx_pos_ff;
      rx_count_in = rx_count_ff;
      rx_pos_in   = rx_pos_ff;
      mode_in     = mode_ff;
      last_err_in = last_err_ff;
      hold_in     = hold_ff;
      rsp         = '0;
      rsp.bus_action = ACT_NONE;
      rsp.link_mode  = MODE_READY;
      wr_en       = 1'b0;
      wr_idx      = '0;
      wr_data     = cmd.data;
      rd_idx      = tx_pos_ff[TX_IDX_W-1:0];
      begin_en    = 1'b0;
      begin_len   = '0;
      next_en     = 1'b0;
      take_en     = 1'b0;
      ackn_en     = 1'b0;
      finish_en   = 1'b0;
      finish_err  = ERR_NONE;

      case (cmd.op)
         OP_LOAD: begin
            if (cmd.slot_ok) begin
               wr_en  = 1'b1;
               wr_idx = TX_IDX_W'(cmd.slot);
            end
         end
         OP_WRITE: begin
            rd_idx = '0;
            if (cmd.too_long) begin
               rsp.reply_code = REPLY_TOO_LONG;
            end else if (!ready_now) begin
               rsp.reply_code = REPLY_BUSY;
            end else begin
               begin_en  = 1'b1;
               begin_len = TX_CNT_W'(cmd.length);
            end
         end
         OP_READ: begin
            rd_idx = '0;
            if (cmd.too_long) begin
               rsp.reply_code = REPLY_TOO_LONG;
            end else begin
               // read count is taken even when the bus is busy
               rx_pos_in   = '0;
               rx_count_in = RX_CNT_W'(cmd.length);
               if (!ready_now) begin
                  rsp.reply_code = REPLY_BUSY;
               end else begin
                  wr_en     = 1'b1;
                  wr_idx    = '0;
                  wr_data   = cmd.addr_byte;
                  begin_en  = 1'b1;
                  begin_len = TX_CNT_W'(1);
               end
            end
         end
         OP_MT_ACK: begin
            mode_in = MODE_MT;
            next_en = 1'b1;
         end
         OP_SEND_MORE: begin
            next_en = 1'b1;
         end
         OP_MR_ADDR: begin
            mode_in = MODE_MR;
            ackn_en = 1'b1;
         end
         OP_RX_ACK: begin
            take_en = 1'b1;
            ackn_en = 1'b1;
         end
         OP_RX_LAST: begin
            take_en   = 1'b1;
            finish_en = 1'b1;
         end
         OP_FAIL: begin
            finish_en  = 1'b1;
            finish_err = cmd.err_code;
         end
         OP_REP: begin
            mode_in = MODE_REP;
         end
         OP_BUS_ERROR: begin
            last_err_in    = ERR_BUS;
            mode_in        = MODE_READY;
            rsp.bus_action = ACT_STOP;
         end
         default: begin
         end
      endcase

      if (begin_en) begin
         hold_in     = cmd.rep;
         tx_count_in = begin_len;
         mode_in     = MODE_INIT;
         if (mode_ff == MODE_REP) begin
            // bus already held: go straight to the first byte
            rsp.bus_action = ACT_SEND;
            rsp.tx_byte    = (cmd.op == OP_READ) ? cmd.addr_byte : buf_rd;
            tx_pos_in      = TX_CNT_W'(1);
         end else begin
            rsp.bus_action = ACT_START;
            tx_pos_in      = '0;
         end
      end

      if (next_en) begin
         if (tx_pos_ff < tx_count_ff) begin
            last_err_in    = ERR_IN_PROGRESS;
            rsp.bus_action = ACT_SEND;
            rsp.tx_byte    = buf_rd;
            tx_pos_in      = tx_pos_ff + 1'b1;
         end else begin
            finish_en = 1'b1;
         end
      end

      if (take_en) begin
         if (rx_pos_ff < RX_CNT_W'(RX_DEPTH)) begin
            rsp.rx_valid = 1'b1;
            rsp.rx_byte  = cmd.data;
            rsp.rx_slot  = 5'(rx_pos_ff);
            rx_pos_in    = rx_pos_ff + 1'b1;
         end
      end

      if (ackn_en) begin
         last_err_in    = ERR_IN_PROGRESS;
         rsp.bus_action = (({1'b0, rx_pos_in} + 1'b1) < {1'b0, rx_count_ff}) ?
                          ACT_ACK : ACT_NACK;
      end

      if (finish_en) begin
         last_err_in = finish_err;
         if (hold_ff) begin
            rsp.bus_action = ACT_START;
         end else begin
            mode_in        = MODE_READY;
            rsp.bus_action = ACT_STOP;
         end
      end

      rsp.link_mode  = mode_in;
      rsp.ready_res  = (mode_in == MODE_READY) || (mode_in == MODE_REP);
      rsp.error_code = last_err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_count_ff <= '0;
         tx_pos_ff   <= '0;
         rx_count_ff <= '0;
         rx_pos_ff   <= '0;
         mode_ff     <= MODE_READY;
         last_err_ff <= ERR_NONE;
         hold_ff     <= 1'b0;
      end else if (cmd_take) begin
         tx_count_ff <= tx_count_in;
         tx_pos_ff   <= tx_pos_in;
         rx_count_ff <= rx_count_in;
         rx_pos_ff   <= rx_pos_in;
         mode_ff     <= mode_in;
         last_err_ff <= last_err_in;
         hold_ff     <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take && wr_en) begin
         tx_buf_ff[wr_idx] <= wr_data;
      end
   end

   a_rx_pos_bound: assert property (@(posedge clock) disable iff (reset)
      rx_pos_ff <= RX_CNT_W'(RX_DEPTH))
      else $error("read position beyond read depth");

   a_busy_write_keeps_mode: assert property (@(posedge clock) disable iff (reset)
      cmd_take && cmd.op == OP_WRITE && rsp.reply_code != REPLY_OK |=> $stable(mode_ff))
      else $error("refused write changed link mode");

   a_tx_byte_only_on_send: assert property (@(posedge clock) disable iff (reset)
      rsp_push && rsp.bus_action != ACT_SEND |-> rsp.tx_byte == 8'h00)
      else $error("transmit byte without send action");

   a_rx_fields_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_push && !rsp.rx_valid |-> rsp.rx_byte == 8'h00 && rsp.rx_slot == 5'd0)
      else $error("receive fields set without a received byte");

endmodule

/* dv/tb_i2c_master_transfer_sequencer.sv */
module tb_i2c_master_transfer_sequencer;
   import i2cms_pkg::*;

   // block sizes as built
   localparam int TXD = TX_DEPTH_DEF;
   localparam int RXD = RX_DEPTH_DEF;

   // status with nothing to act on
   localparam logic [7:0] ST_NO_INFO = 8'hF8;

   // accepted items to aim for, directed rows included, events of no known status not counted
   localparam int ITEM_TARGET = 1575;
   // stretch of items with no idling on either side
   localparam int CALM_FROM = 600;
   localparam int CALM_TO   = 900;
   // time for a response to pass through both queues, with margin
   localparam int TAIL_CYCLES = 8;
   localparam int DRAIN_LIMIT = 2000;
   localparam int CYCLE_LIMIT = 100000;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
      logic [4:0] buffer_slot;
      logic [7:0] length;
      logic       rep_start;
      logic [6:0] slave_address;
      logic [7:0] status_code;
   } req_item_type;

   // one row of the directed table; want is only used where fixed_rsp is set
   typedef struct packed {
      req_item_type item;
      logic         fixed_rsp;
      rsp_type      want;
   } dir_row_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic [1:0] req_command = CMD_LOAD;
   logic [7:0] req_data_byte = '0;
   logic [4:0] req_buffer_slot = '0;
   logic [7:0] req_length = '0;
   logic       req_rep_start = 1'b0;
   logic [6:0] req_slave_address = '0;
   logic [7:0] req_status_code = '0;
   logic       empty;
   logic       pop = 1'b0;
   logic [2:0] rsp_bus_action;
   logic [7:0] rsp_tx_byte;
   logic       rsp_rx_valid;
   logic [7:0] rsp_rx_byte;
   logic [4:0] rsp_rx_slot;
   logic [1:0] rsp_reply_code;
   logic       rsp_ready_res;
   logic [2:0] rsp_link_mode;
   logic [7:0] rsp_error_code;

   i2c_master_transfer_sequencer DUT (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_command       (req_command),
      .req_data_byte     (req_data_byte),
      .req_buffer_slot   (req_buffer_slot),
      .req_length        (req_length),
      .req_rep_start     (req_rep_start),
      .req_slave_address (req_slave_address),
      .req_status_code   (req_status_code),
      .empty             (empty),
      .pop               (pop),
      .rsp_bus_action    (rsp_bus_action),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_rx_valid      (rsp_rx_valid),
      .rsp_rx_byte       (rsp_rx_byte),
      .rsp_rx_slot       (rsp_rx_slot),
      .rsp_reply_code    (rsp_reply_code),
      .rsp_ready_res     (rsp_ready_res),
      .rsp_link_mode     (rsp_link_mode),
      .rsp_error_code    (rsp_error_code)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // shadow of the sequencer: transmit buffer, counters, link and status
   // ------------------------------------------------------------------
   logic [7:0] tx_mem [TXD];
   bit         tx_loaded [TXD];   // slots written since the start of the run
   logic [5:0] tx_len = '0;
   logic [5:0] tx_next = '0;
   logic [7:0] rx_len = '0;
   logic [5:0] rx_next = '0;
   mode_type   link = MODE_READY;
   logic [7:0] last_status = ERR_NONE;
   logic       keep_bus = 1'b0;
   rsp_type    step;               // bus step being worked out for the current item

   // expected bus steps, oldest first
   rsp_type awaited_bus_steps [$];

   int  fail_count = 0;
   int  work_items = 0;
   int  n_writes = 0;
   int  n_reads = 0;
   int  n_rx_bytes = 0;
   int  n_rx_dropped = 0;
   int  cycle_count = 0;
   logic calm = 1'b0;

   string field_names [9] = '{"bus_action", "tx_byte", "rx_valid", "rx_byte", "rx_slot",
                              "reply_code", "ready_res", "link_mode", "error_code"};

   function automatic bit link_idle();
      return link == MODE_READY || link == MODE_REP;
   endfunction

   function automatic void send_next_byte();
      step.bus_action = ACT_SEND;
      step.tx_byte = (tx_next < TXD) ? tx_mem[tx_next[4:0]] : 8'h00;
      tx_next = tx_next + 6'd1;
   endfunction

   // a held bus goes straight to the first byte, otherwise a start goes out first
   function automatic logic [1:0] open_write(input logic [7:0] len, input logic rep);
      if (len > TXD) return REPLY_TOO_LONG;
      if (!link_idle()) return REPLY_BUSY;
      keep_bus = rep;
      tx_len = len[5:0];
      tx_next = '0;
      if (link == MODE_REP) begin
         link = MODE_INIT;
         send_next_byte();
      end else begin
         link = MODE_INIT;
         step.bus_action = ACT_START;
      end
      return REPLY_OK;
   endfunction

   function automatic void close_transfer(input logic [7:0] status);
      last_status = status;
      if (keep_bus) begin
         step.bus_action = ACT_START;
      end else begin
         link = MODE_READY;
         step.bus_action = ACT_STOP;
      end
   endfunction

   // a read count of zero behaves as one byte
   function automatic void answer_rx();
      last_status = ERR_IN_PROGRESS;
      step.bus_action = (int'(rx_next) + 1 < int'(rx_len)) ? ACT_ACK : ACT_NACK;
   endfunction

   function automatic void take_rx(input logic [7:0] b);
      if (rx_next < RXD) begin
         step.rx_valid = 1'b1;
         step.rx_byte = b;
         step.rx_slot = rx_next[4:0];
         rx_next = rx_next + 6'd1;
      end else begin
         n_rx_dropped++;
      end
   endfunction

   function automatic rsp_type next_bus_step(input req_item_type it);
      logic [7:0] code;
      code = it.status_code & STATUS_MASK;
      step = '0;
      case (it.command)
         CMD_LOAD: begin
            tx_mem[it.buffer_slot] = it.data_byte;
            tx_loaded[it.buffer_slot] = 1'b1;
         end
         CMD_WRITE: step.reply_code = open_write(it.length, it.rep_start);
         CMD_READ: begin
            if (it.length > RXD) begin
               step.reply_code = REPLY_TOO_LONG;
            end else begin
               // the read count is taken even when the link is busy
               rx_next = '0;
               rx_len = it.length;
               if (!link_idle()) begin
                  step.reply_code = REPLY_BUSY;
               end else begin
                  tx_mem[0] = {it.slave_address, 1'b1};
                  tx_loaded[0] = 1'b1;
                  step.reply_code = open_write(8'd1, it.rep_start);
               end
            end
         end
         default: begin
            case (code)
               ST_START, ST_SLA_W_ACK, ST_DATA_ACK: begin
                  if (code == ST_SLA_W_ACK) link = MODE_MT;
                  if (tx_next < tx_len) begin
                     last_status = ERR_IN_PROGRESS;
                     send_next_byte();
                  end else begin
                     close_transfer(ERR_NONE);
                  end
               end
               ST_SLA_R_ACK: begin
                  link = MODE_MR;
                  answer_rx();
               end
               ST_RX_ACK: begin
                  take_rx(it.data_byte);
                  answer_rx();
               end
               ST_RX_NACK: begin
                  take_rx(it.data_byte);
                  close_transfer(ERR_NONE);
               end
               ST_SLA_W_NACK, ST_DATA_NACK, ST_ARB_LOST, ST_SLA_R_NACK: close_transfer(code);
               ST_REP_START: link = MODE_REP;
               ST_BUS_ERROR: begin
                  last_status = ERR_BUS;
                  link = MODE_READY;
                  step.bus_action = ACT_STOP;
               end
               default: ;
            endcase
         end
      endcase
      step.ready_res = link_idle();
      step.link_mode = link;
      step.error_code = last_status;
      return step;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic req_item_type rand_item(input logic [1:0] cmd);
      req_item_type it;
      it.command = cmd;
      it.data_byte = 8'($urandom);
      it.buffer_slot = 5'($urandom);
      it.length = 8'($urandom);
      it.rep_start = 1'($urandom);
      it.slave_address = 7'($urandom);
      it.status_code = 8'($urandom);
      return it;
   endfunction

   // the low three status bits are noise and get random values
   function automatic req_item_type bus_event(input logic [7:0] code);
      req_item_type it;
      it = rand_item(CMD_EVENT);
      it.status_code = code | 8'($urandom_range(7));
      return it;
   endfunction

   // mostly short transfers, now and then the largest, some over the limit
   function automatic logic [7:0] pick_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return 8'($urandom_range(0, 6));
      if (roll < 80) return 8'(TXD);
      if (roll < 88) return 8'($urandom_range(TXD + 1, 255));
      return 8'($urandom_range(7, TXD - 1));
   endfunction

   // push one item through the request side; a send from a buffer slot that
   // was never loaded is headed off by loading that slot first
   task automatic offer(input req_item_type it, input bit use_fixed = 1'b0,
                        input rsp_type want = '0);
      req_item_type cur;
      rsp_type      predicted;
      logic [7:0]   code;
      int           unloaded;
      bit           done;
      done = 1'b0;
      while (!done) begin
         code = it.status_code & STATUS_MASK;
         unloaded = -1;
         if (it.command == CMD_WRITE && it.length <= TXD && link == MODE_REP && !tx_loaded[0])
            unloaded = 0;
         if (it.command == CMD_EVENT && code inside {ST_START, ST_SLA_W_ACK, ST_DATA_ACK}
             && tx_next < tx_len && !tx_loaded[tx_next[4:0]])
            unloaded = int'(tx_next);
         cur = it;
         if (unloaded >= 0) begin
            cur = rand_item(CMD_LOAD);
            cur.buffer_slot = 5'(unloaded);
         end else begin
            done = 1'b1;
         end
         // random idle cycles before the transfer, none in the calm stretch
         while (!calm && $urandom_range(99) < 16) begin
            push <= 1'b0;
            @(posedge clock);
         end
         req_command <= cur.command;
         req_data_byte <= cur.data_byte;
         req_buffer_slot <= cur.buffer_slot;
         req_length <= cur.length;
         req_rep_start <= cur.rep_start;
         req_slave_address <= cur.slave_address;
         req_status_code <= cur.status_code;
         push <= 1'b1;
         @(posedge clock);
         while (full) @(posedge clock);
         // transfer taken at this edge; push stays high unless the next call idles
         predicted = next_bus_step(cur);
         awaited_bus_steps.push_back((done && use_fixed) ? want : predicted);
         if (!(cur.command == CMD_EVENT && !((cur.status_code & STATUS_MASK) inside
               {ST_BUS_ERROR, ST_START, ST_REP_START, ST_SLA_W_ACK, ST_SLA_W_NACK,
                ST_DATA_ACK, ST_DATA_NACK, ST_ARB_LOST, ST_SLA_R_ACK, ST_SLA_R_NACK,
                ST_RX_ACK, ST_RX_NACK})))
            work_items++;
         if (cur.command == CMD_WRITE && predicted.reply_code == REPLY_OK) n_writes++;
         if (cur.command == CMD_READ && predicted.reply_code == REPLY_OK) n_reads++;
         if (predicted.rx_valid) n_rx_bytes++;
         calm <= (work_items >= CALM_FROM && work_items < CALM_TO);
      end
   endtask

   // ------------------------------------------------------------------
   // directed table: reply codes, both ends of every field, all status codes but
   // write address NACK, arbitration lost and receive ACK, busy starts, a
   // zero-length write on a held bus and a zero-length read
   dir_row_type directed_rows [25] = '{
      // no-info status from reset: nothing happens
      '{'{CMD_EVENT, 8'h00, 5'd0, 8'd0, 1'b0, 7'd0, ST_NO_INFO}, 1'b1,
        '{ACT_NONE, 8'h00, 1'b0, 8'h00, 5'd0, REPLY_OK, 1'b1, MODE_READY, ERR_NONE}},
      // write one byte over the limit, read at the largest length
      '{'{CMD_WRITE, 8'h00, 5'd0, 8'd33, 1'b0, 7'd0, 8'h00}, 1'b1,
        '{ACT_NONE, 8'h00, 1'b0, 8'h00, 5'd0, REPLY_TOO_LONG, 1'b1, MODE_READY, ERR_NONE}},
      '{'{CMD_READ, 8'h00, 5'd0, 8'd255, 1'b1, 7'h7F, 8'h00}, 1'b1,
        '{ACT_NONE, 8'h00, 1'b0, 8'h00, 5'd0, REPLY_TOO_LONG, 1'b1, MODE_READY, ERR_NONE}},
      // buffer loads at both ends
      '{'{CMD_LOAD, 8'h00, 5'd0, 8'd0, 1'b0, 7'd0, 8'h00}, 1'b0, '0},
      '{'{CMD_LOAD, 8'hFF, 5'd31, 8'hFF, 1'b1, 7'h7F, 8'hFF}, 1'b0, '0},
      '{'{CMD_LOAD, 8'hA5, 5'd1, 8'd0, 1'b0, 7'd0, 8'h00}, 1'b0, '0},
      // two-byte write, then a second start while busy
      '{'{CMD_WRITE, 8'h00, 5'd0, 8'd2, 1'b0, 7'd0, 8'h00}, 1'b1,
        '{ACT_START, 8'h00, 1'b0, 8'h00, 5'd0, REPLY_OK, 1'b0, MODE_INIT, ERR_NONE}},
      '{'{CMD_WRITE, 8'h00, 5'd0, 8'd2, 1'b0, 7'd0, 8'h00}, 1'b1,
        '{ACT_NONE, 8'h00, 1'b0, 8'h00, 5'd0, REPLY_BUSY, 1'b0, MODE_INIT, ERR_NONE}},
      '{'{CMD_EVENT, 8'h00, 5'd0, 8'd0, 1'b0, 7'd0, ST_START}, 1'b0, '0},
      '{'{CMD_EVENT, 8'h00, 5'd0, 8'd0, 1'b0, 7'd0, ST_SLA_W_ACK}, 1'b0, '0},
      '{'{CMD_EVENT, 8'h00, 5'd0, 8'd0, 1'b0, 7'd0, ST_DATA_ACK}, 1'b1,
        '{ACT_STOP, 8'h00, 1'b0, 8'h00, 5'd0, REPLY_OK, 1'b1, MODE_READY, ERR_NONE}},
      // empty write keeping the bus, repeated start, then an empty write on the held bus
      '{'{CMD_WRITE, 8'h00, 5'd0, 8'd0, 1'b1, 7'd0, 8'h00}, 1'b0, '0},
      '{'{CMD_EVENT, 8'h00, 5'd0, 8'd0, 1'b0, 7'd0, ST_START}, 1'b0, '0},
      '{'{CMD_EVENT, 8'h00, 5'd0, 8'd0, 1'b0, 7'd0, ST_REP_START}, 1'b1,
        '{ACT_NONE, 8'h00, 1'b0, 8'h00, 5'd0, REPLY_OK, 1'b1, MODE_REP, ERR_NONE}},
      '{'{CMD_WRITE, 8'h00, 5'd0, 8'd0, 1'b0, 7'd0, 8'h00}, 1'b0, '0},
      // data NACK with the low status bits set
      '{'{CMD_EVENT, 8'h00, 5'd0, 8'd0, 1'b0, 7'd0, ST_DATA_NACK | 8'h07}, 1'b1,
        '{ACT_STOP, 8'h00, 1'b0, 8'h00, 5'd0, REPLY_OK, 1'b1, MODE_READY, ST_DATA_NACK}},
      // zero-length read from the top address: NACK at once
      '{'{CMD_READ, 8'h00, 5'd0, 8'd0, 1'b0, 7'h7F, 8'h00}, 1'b0, '0},
      '{'{CMD_EVENT, 8'h00, 5'd0, 8'd0, 1'b0, 7'd0, ST_START}, 1'b0, '0},
      '{'{CMD_EVENT, 8'h00, 5'd0, 8'd0, 1'b0, 7'd0, ST_SLA_R_ACK}, 1'b0, '0},
      '{'{CMD_EVENT, 8'hFF, 5'd0, 8'd0, 1'b0, 7'd0, ST_RX_NACK}, 1'b0, '0},
      '{'{CMD_EVENT, 8'h00, 5'd0, 8'd0, 1'b0, 7'd0, ST_BUS_ERROR}, 1'b1,
        '{ACT_STOP, 8'h00, 1'b0, 8'h00, 5'd0, REPLY_OK, 1'b1, MODE_READY, ERR_BUS}},
      // full-size read, a busy read that still sets the count, then address NACK
      '{'{CMD_READ, 8'h00, 5'd0, 8'd32, 1'b0, 7'd0, 8'h00}, 1'b0, '0},
      '{'{CMD_READ, 8'h00, 5'd0, 8'd5, 1'b0, 7'h55, 8'h00}, 1'b1,
        '{ACT_NONE, 8'h00, 1'b0, 8'h00, 5'd0, REPLY_BUSY, 1'b0, MODE_INIT, ERR_BUS}},
      '{'{CMD_EVENT, 8'h00, 5'd0, 8'd0, 1'b0, 7'd0, ST_START}, 1'b0, '0},
      '{'{CMD_EVENT, 8'h00, 5'd0, 8'd0, 1'b0, 7'd0, ST_SLA_R_NACK | 8'h07}, 1'b0, '0}
   };

   // ------------------------------------------------------------------
   // request side: reset, directed table, random transfers, then drain
   // ------------------------------------------------------------------
   initial begin
      req_item_type it;
      int           pick;
      int           roll;
      int           overrun;
      int           k;
      int           drain;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         offer(directed_rows[r].item, directed_rows[r].fixed_rsp, directed_rows[r].want);

      while (work_items < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            // master write: a few loads, the start, address and data phases
            repeat ($urandom_range(0, 3)) begin
               it = rand_item(CMD_LOAD);
               if ($urandom_range(3) != 0) it.buffer_slot = 5'($urandom_range(0, 7));
               offer(it);
            end
            it = rand_item(CMD_WRITE);
            it.length = pick_length();
            offer(it);
            if (step.bus_action == ACT_START) offer(bus_event(ST_START));
            roll = $urandom_range(99);
            offer(bus_event(roll < 5 ? ST_SLA_W_NACK : roll < 8 ? ST_ARB_LOST : ST_SLA_W_ACK));
            for (k = 0; k < 40 && step.bus_action == ACT_SEND; k++)
               offer(bus_event($urandom_range(99) < 5 ? ST_DATA_NACK : ST_DATA_ACK));
            if (step.bus_action == ACT_START && $urandom_range(4) != 0)
               offer(bus_event(ST_REP_START));
         end else if (pick < 75) begin
            // master read: address phase, data bytes, sometimes past the end
            it = rand_item(CMD_READ);
            it.length = pick_length();
            offer(it);
            if (step.bus_action == ACT_START) offer(bus_event(ST_START));
            roll = $urandom_range(99);
            offer(bus_event(roll < 8 ? ST_SLA_R_NACK : roll < 12 ? ST_ARB_LOST : ST_SLA_R_ACK));
            overrun = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : 0;
            for (k = 0; k < 40 && step.bus_action == ACT_ACK; k++)
               offer(bus_event(ST_RX_ACK));
            for (k = 0; k < overrun && link == MODE_MR; k++)
               offer(bus_event(ST_RX_ACK));
            if (link == MODE_MR) offer(bus_event(ST_RX_NACK));
            if (step.bus_action == ACT_START && $urandom_range(4) != 0)
               offer(bus_event(ST_REP_START));
         end else if (pick < 82) begin
            // a stray bus condition at whatever point the link has reached
            roll = $urandom_range(3);
            offer(bus_event(roll == 0 ? ST_BUS_ERROR : roll == 1 ? ST_ARB_LOST :
                            roll == 2 ? ST_REP_START : ST_DATA_NACK));
         end else begin
            // noise: anything at all
            repeat ($urandom_range(1, 3)) offer(rand_item(2'($urandom)));
         end
      end
      push <= 1'b0;

      // let every outstanding response through, then watch for strays
      drain = 0;
      while (awaited_bus_steps.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_bus_steps.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, awaited_bus_steps.size());
         fail_count += awaited_bus_steps.size();
      end

      $display("run covered %0d items with %0d writes and %0d reads started,",
               work_items, n_writes, n_reads);
      $display("%0d bytes received and %0d dropped past the read limit, %0d field mismatches",
               n_rx_bytes, n_rx_dropped, fail_count);
      if (fail_count == 0) begin
         $display("tb_i2c_master_transfer_sequencer passed");
      end else begin
         $display("tb_i2c_master_transfer_sequencer failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // response side: random pop stalls, each transfer checked field by field
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type    want;
      logic [7:0] exp_f [9];
      logic [7:0] got_f [9];
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (awaited_bus_steps.size() == 0) begin
               $display("%0t: response with nothing outstanding, bus_action %0d error_code %0h",
                        $time, rsp_bus_action, rsp_error_code);
               fail_count++;
            end else begin
               want = awaited_bus_steps.pop_front();
               exp_f = '{want.bus_action, want.tx_byte, want.rx_valid, want.rx_byte,
                         want.rx_slot, want.reply_code, want.ready_res, want.link_mode,
                         want.error_code};
               got_f = '{rsp_bus_action, rsp_tx_byte, rsp_rx_valid, rsp_rx_byte,
                         rsp_rx_slot, rsp_reply_code, rsp_ready_res, rsp_link_mode,
                         rsp_error_code};
               for (int i = 0; i < 9; i++) begin
                  if (got_f[i] !== exp_f[i]) begin
                     $display("%0t: %s expected %0h actual %0h",
                              $time, field_names[i], exp_f[i], got_f[i]);
                     fail_count++;
                  end
               end
            end
         end
         pop <= calm || ($urandom_range(99) >= 16);
      end
   end

   // watchdog on total run length
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("%0t: run timed out after %0d cycles", $time, cycle_count);
      $display("tb_i2c_master_transfer_sequencer failed");
      $finish;
   end

endmodule
